// File: rtl/brm_pkg.sv
// Package for the banked register file with mode switching and interrupt entry.
// Holds the operation codes, mode numbers, bank slot numbers and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brm_pkg;

   // Operation codes carried by an input transaction.
   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_SWITCH = 3'd2,
      OP_RAISE  = 3'd3,
      OP_CLEAR  = 3'd4,
      OP_HALT   = 3'd5
   } op_type;

   // Processor modes that the logic treats specially.
   localparam logic [2:0] MODE_USER = 3'd0;
   localparam logic [2:0] MODE_INTR = 3'd1;
   localparam logic [2:0] MODE_FAST = 3'd2;

   // Bank layout: slots 0 to 6 hold copies of r8 to r14.
   localparam int BANK_SLOTS  = 7;
   localparam int BANK_BASE   = 8;
   localparam int SP_SLOT     = 5;
   localparam int LR_SLOT     = 6;
   localparam int NUM_LIVE    = 16;
   localparam logic [3:0] PC_INDEX = 4'd15;

   // Register index that selects the status word.
   localparam logic [4:0] STATUS_INDEX = 5'd16;
   localparam int STATUS_I_BIT = 7;

   // Interrupt entry values.
   localparam logic [31:0] IRQ_STATUS   = 32'h0000_00D2;
   localparam logic [31:0] IRQ_VECTOR   = 32'h0000_0018;
   localparam logic [31:0] BIOS_PROTECT = 32'hE55E_C002;
   localparam logic [31:0] PC_STEP      = 32'd4;

   // Configuration register indexes (taken from address bit 2).
   localparam logic CSR_MASTER_ENABLE = 1'b0;
   localparam logic CSR_LINE_ENABLE   = 1'b1;

   // Result fields of fixed width that travel from the register file to the top.
   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_taken;
      logic [2:0]  current_mode;
      logic        core_running;
      logic [31:0] bios_latch;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/brm_csr.sv
// Configuration registers behind the APB-style port: master enable and line enables.
// Depends on brm_pkg for the register index constants.
`timescale 1ns / 1ps
`default_nettype none

module brm_csr #(
   parameter int IRQ_LINES = 14
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready,
   output logic                      master_enable,
   output logic      [IRQ_LINES-1:0] line_enable
);
   import brm_pkg::*;

   logic                 master_enable_ff;
   logic                 master_enable_in;
   logic [IRQ_LINES-1:0] line_enable_ff;
   logic [IRQ_LINES-1:0] line_enable_in;
   logic                 write_strobe;

   assign pready       = 1'b1;
   assign write_strobe = psel && penable && pwrite && pready;

   // Register update on the access phase of a write transaction.
   always_comb begin
      master_enable_in = master_enable_ff;
      line_enable_in   = line_enable_ff;
      if (write_strobe) begin
         unique case (paddr[2])
            CSR_MASTER_ENABLE: master_enable_in = pwdata[0];
            CSR_LINE_ENABLE:   line_enable_in   = pwdata[IRQ_LINES-1:0];
            default:           master_enable_in = master_enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_enable_ff <= 1'b0;
         line_enable_ff   <= '0;
      end else begin
         master_enable_ff <= master_enable_in;
         line_enable_ff   <= line_enable_in;
      end
   end

   // Read back the selected register.
   always_comb begin
      unique case (paddr[2])
         CSR_MASTER_ENABLE: prdata = {31'd0, master_enable_ff};
         CSR_LINE_ENABLE:   prdata = 32'(line_enable_ff);
         default:           prdata = '0;
      endcase
   end

   assign master_enable = master_enable_ff;
   assign line_enable   = line_enable_ff;

endmodule

`default_nettype wire

// File: rtl/brm_regs.sv
// Architectural state: live registers, status word, mode, per-mode banks, pending
// flags, halt and protect latch, with the registered update for each transaction.
// Depends on brm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brm_regs #(
   parameter int NUM_MODES = 6,
   parameter int IRQ_LINES = 14
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  brm_pkg::op_type           operation,
   input  wire logic [4:0]           reg_index,
   input  wire logic [31:0]          write_data,
   input  wire logic [2:0]           target_mode,
   input  wire logic [IRQ_LINES-1:0] irq_lines,
   input  wire logic                 master_enable,
   input  wire logic [IRQ_LINES-1:0] line_enable,
   output brm_pkg::rsp_type          rsp,
   output logic      [IRQ_LINES-1:0] pending_irqs
);
   import brm_pkg::*;

   localparam int MW = (NUM_MODES > 2) ? $clog2(NUM_MODES) : 1;

   // State registers.
   logic [31:0]          live_ff [NUM_LIVE];
   logic [31:0]          live_in [NUM_LIVE];
   logic [31:0]          bank_ff [NUM_MODES][BANK_SLOTS];
   logic [31:0]          bank_in [NUM_MODES][BANK_SLOTS];
   logic [31:0]          status_ff;
   logic [31:0]          status_in;
   logic [2:0]           mode_ff;
   logic [2:0]           mode_in;
   logic [IRQ_LINES-1:0] pending_ff;
   logic [IRQ_LINES-1:0] pending_in;
   logic                 halted_ff;
   logic                 halted_in;
   logic [31:0]          protect_ff;
   logic [31:0]          protect_in;

   // Step decode.
   logic [IRQ_LINES-1:0] pending_raised;
   logic                 take_irq;
   logic [2:0]           sw_target;
   logic                 sw_do;
   logic [MW-1:0]        old_row;
   logic [MW-1:0]        new_row;
   logic [31:0]          lr_entry;
   logic [31:0]          restore_row [BANK_SLOTS];
   logic [31:0]          read_value;

   assign pending_raised = pending_ff | irq_lines;
   assign take_irq = (operation == OP_RAISE) && master_enable
                     && (|(line_enable & pending_raised)) && !status_ff[STATUS_I_BIT];
   assign lr_entry = live_ff[PC_INDEX] + PC_STEP;

   // A mode switch comes from a switch transaction or from interrupt entry.
   always_comb begin
      sw_target = take_irq ? MODE_INTR : target_mode;
      sw_do = ((operation == OP_SWITCH) || take_irq)
              && ({1'b0, sw_target} < 4'(NUM_MODES)) && (sw_target != mode_ff);
      old_row = mode_ff[MW-1:0];
      new_row = sw_target[MW-1:0];
   end

   // Bank row of the new mode; on interrupt entry the fresh LR copy bypasses the store.
   always_comb begin
      for (int s = 0; s < BANK_SLOTS; s++) begin
         restore_row[s] = bank_ff[new_row][s];
      end
      if (take_irq) begin
         restore_row[LR_SLOT] = lr_entry;
      end
   end

   // Bank store update: interrupt LR copy, then the save of the old mode's copies.
   always_comb begin
      bank_in = bank_ff;
      if (take_irq) begin
         bank_in[MODE_INTR[MW-1:0]][LR_SLOT] = lr_entry;
      end
      if (sw_do) begin
         for (int s = 0; s < BANK_SLOTS; s++) begin
            if ((sw_target == MODE_FAST) || (s >= SP_SLOT)) begin
               bank_in[old_row][s] = live_ff[BANK_BASE + s];
            end
         end
      end
   end

   // Live register update: plain write, PC redirect and restore from the new bank.
   always_comb begin
      live_in = live_ff;
      if ((operation == OP_WRITE) && !reg_index[4]) begin
         live_in[reg_index[3:0]] = write_data;
      end
      if (take_irq) begin
         live_in[PC_INDEX] = IRQ_VECTOR;
      end
      if (sw_do) begin
         for (int s = 0; s < BANK_SLOTS; s++) begin
            if ((mode_ff == MODE_FAST) || (s >= SP_SLOT)) begin
               live_in[BANK_BASE + s] = restore_row[s];
            end
         end
      end
   end

   // Scalar state update.
   always_comb begin
      status_in  = status_ff;
      pending_in = pending_ff;
      halted_in  = halted_ff;
      protect_in = protect_ff;
      read_value = '0;
      unique case (operation)
         OP_READ: begin
            if (!reg_index[4]) begin
               read_value = live_ff[reg_index[3:0]];
            end else if (reg_index == STATUS_INDEX) begin
               read_value = status_ff;
            end
         end
         OP_WRITE: begin
            if (reg_index == STATUS_INDEX) begin
               status_in = write_data;
            end
         end
         OP_RAISE: begin
            pending_in = pending_raised;
            if (take_irq) begin
               status_in  = IRQ_STATUS;
               halted_in  = 1'b0;
               protect_in = BIOS_PROTECT;
            end
         end
         OP_CLEAR: pending_in = pending_ff & ~irq_lines;
         OP_HALT:  halted_in  = 1'b1;
         default:  read_value = '0;
      endcase
      mode_in = sw_do ? sw_target : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_LIVE; r++) begin
            live_ff[r] <= '0;
         end
         for (int m = 0; m < NUM_MODES; m++) begin
            for (int s = 0; s < BANK_SLOTS; s++) begin
               bank_ff[m][s] <= '0;
            end
         end
         status_ff  <= '0;
         mode_ff    <= MODE_USER;
         pending_ff <= '0;
         halted_ff  <= 1'b0;
         protect_ff <= '0;
      end else if (step_en) begin
         live_ff    <= live_in;
         bank_ff    <= bank_in;
         status_ff  <= status_in;
         mode_ff    <= mode_in;
         pending_ff <= pending_in;
         halted_ff  <= halted_in;
         protect_ff <= protect_in;
      end
   end

   // Result of this transaction, as seen after the update.
   always_comb begin
      rsp.read_data    = read_value;
      rsp.irq_taken    = take_irq;
      rsp.current_mode = mode_in;
      rsp.core_running = !halted_in;
      rsp.bios_latch   = protect_in;
   end
   assign pending_irqs = pending_in;

   // Interrupt entry lands in irq mode with the vector in the PC and masked status.
   a_irq_entry: assert property (@(posedge clock) disable iff (reset)
      step_en && take_irq |=> (mode_ff == MODE_INTR) && (live_ff[PC_INDEX] == IRQ_VECTOR)
                              && (status_ff == IRQ_STATUS))
      else $error("interrupt entry did not reach irq mode with vector and status");

   // Interrupt entry always wakes the processor.
   a_irq_wakes: assert property (@(posedge clock) disable iff (reset)
      step_en && take_irq |=> !halted_ff && (protect_ff == BIOS_PROTECT))
      else $error("interrupt entry left the processor halted or unprotected");

   // The mode changes only through a switch or an interrupt entry.
   a_mode_source: assert property (@(posedge clock) disable iff (reset)
      !(step_en && ((operation == OP_SWITCH) || take_irq)) |=> $stable(mode_ff))
      else $error("mode changed without a switch or interrupt entry");

   // Without a transaction the state holds.
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(pending_ff) && $stable(status_ff) && $stable(halted_ff))
      else $error("state changed while no transaction was processed");

endmodule

`default_nettype wire

// File: rtl/banked_register_mode_and_irq_entry_core.sv
// A transaction is held in the input register, then the state update writes its result
// into the result register, which drives the response ports. Throughput: one transaction
// per cycle while the response side does not stall; each access, mode switch or interrupt
// entry is done by a single update of the state stage.
// Reset (synchronous, active high) clears the state, banks, flags, config and valid bits.
// Top level of the banked register file; depends on brm_pkg, brm_csr and brm_regs.
`timescale 1ns / 1ps
`default_nettype none

module banked_register_mode_and_irq_entry_core #(
   parameter int NUM_MODES = 6,
   parameter int IRQ_LINES = 14
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [2:0]           req_operation,
   input  wire logic [4:0]           req_reg_index,
   input  wire logic [31:0]          req_write_data,
   input  wire logic [2:0]           req_target_mode,
   input  wire logic [IRQ_LINES-1:0] req_irq_lines,
   // Response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [31:0]          rsp_read_data,
   output logic                      rsp_irq_taken,
   output logic      [2:0]           rsp_current_mode,
   output logic      [IRQ_LINES-1:0] rsp_pending_irqs,
   output logic                      rsp_core_running,
   output logic                      rsp_pc_changed,
   output logic      [31:0]          rsp_bios_latch,
   // Configuration port
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic      [31:0]          csr_prdata,
   output logic                      csr_pready
);
   import brm_pkg::*;

   // Input register.
   logic                 in_valid_ff;
   logic                 in_valid_in;
   op_type               in_op_ff;
   logic [4:0]           in_index_ff;
   logic [31:0]          in_data_ff;
   logic [2:0]           in_mode_ff;
   logic [IRQ_LINES-1:0] in_lines_ff;

   // Result register.
   logic                 out_valid_ff;
   logic                 out_valid_in;
   rsp_type              out_rsp_ff;
   logic [IRQ_LINES-1:0] out_pending_ff;

   logic                 advance;
   logic                 accept;
   logic                 master_enable;
   logic [IRQ_LINES-1:0] line_enable;
   rsp_type              step_rsp;
   logic [IRQ_LINES-1:0] step_pending;

   // Handshake: a held transaction moves on when the result register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff    <= op_type'(req_operation);
         in_index_ff <= req_reg_index;
         in_data_ff  <= req_write_data;
         in_mode_ff  <= req_target_mode;
         in_lines_ff <= req_irq_lines;
      end
      if (advance) begin
         out_rsp_ff     <= step_rsp;
         out_pending_ff <= step_pending;
      end
   end

   brm_csr #(
      .IRQ_LINES (IRQ_LINES)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .master_enable (master_enable),
      .line_enable   (line_enable)
   );

   brm_regs #(
      .NUM_MODES (NUM_MODES),
      .IRQ_LINES (IRQ_LINES)
   ) u_regs (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .operation     (in_op_ff),
      .reg_index     (in_index_ff),
      .write_data    (in_data_ff),
      .target_mode   (in_mode_ff),
      .irq_lines     (in_lines_ff),
      .master_enable (master_enable),
      .line_enable   (line_enable),
      .rsp           (step_rsp),
      .pending_irqs  (step_pending)
   );

   // Response ports.
   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_rsp_ff.read_data;
   assign rsp_irq_taken    = out_rsp_ff.irq_taken;
   assign rsp_current_mode = out_rsp_ff.current_mode;
   assign rsp_pending_irqs = out_pending_ff;
   assign rsp_core_running = out_rsp_ff.core_running;
   assign rsp_pc_changed   = out_rsp_ff.irq_taken;
   assign rsp_bios_latch   = out_rsp_ff.bios_latch;

endmodule

`default_nettype wire

// File: tb/tb_banked_register_mode_and_irq_entry_core.sv
// Self-checking testbench for the banked register file with mode switching and IRQ entry.
// Depends on brm_pkg and banked_register_mode_and_irq_entry_core; the expected results
// come from a behavioral copy of the register file, the mode banks and the interrupt logic.
`timescale 1ns / 1ps

module tb_banked_register_mode_and_irq_entry_core;
   import brm_pkg::*;

   localparam int          NUM_MODES   = 6;
   localparam int          IRQ_LINES   = 14;
   localparam int          QUIET_LIMIT = 2000;
   localparam int          RANDOM_ITEMS = 2000;
   localparam int          MAX_WAIT    = 18;
   localparam logic [2:0]  MODE_UND    = 3'd5;
   localparam logic [2:0]  OP_SPARE_LO = 3'd6;
   localparam logic [2:0]  OP_SPARE_HI = 3'd7;
   localparam logic [4:0]  LR_INDEX    = 5'd14;
   localparam logic [4:0]  SP_INDEX    = 5'd13;
   localparam logic [IRQ_LINES-1:0] ALL_LINES = {IRQ_LINES{1'b1}};

   // One result as the block should report it.
   typedef struct {
      logic [31:0]          read_data;
      logic                 irq_taken;
      logic [2:0]           current_mode;
      logic [IRQ_LINES-1:0] pending_irqs;
      logic                 core_running;
      logic                 pc_changed;
      logic [31:0]          bios_latch;
   } core_outcome_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [2:0]           req_operation;
   logic [4:0]           req_reg_index;
   logic [31:0]          req_write_data;
   logic [2:0]           req_target_mode;
   logic [IRQ_LINES-1:0] req_irq_lines;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [31:0]          rsp_read_data;
   logic                 rsp_irq_taken;
   logic [2:0]           rsp_current_mode;
   logic [IRQ_LINES-1:0] rsp_pending_irqs;
   logic                 rsp_core_running;
   logic                 rsp_pc_changed;
   logic [31:0]          rsp_bios_latch;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [2:0]           csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   banked_register_mode_and_irq_entry_core #(
      .NUM_MODES(NUM_MODES),
      .IRQ_LINES(IRQ_LINES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_reg_index(req_reg_index),
      .req_write_data(req_write_data),
      .req_target_mode(req_target_mode),
      .req_irq_lines(req_irq_lines),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_irq_taken(rsp_irq_taken),
      .rsp_current_mode(rsp_current_mode),
      .rsp_pending_irqs(rsp_pending_irqs),
      .rsp_core_running(rsp_core_running),
      .rsp_pc_changed(rsp_pc_changed),
      .rsp_bios_latch(rsp_bios_latch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the register file, banks, interrupt state and configuration.
   logic [31:0]          m_regs [NUM_LIVE];
   logic [31:0]          m_bank [NUM_MODES][BANK_SLOTS];
   logic [31:0]          m_spsr [NUM_MODES];
   logic [31:0]          m_status;
   logic [2:0]           m_mode;
   logic [IRQ_LINES-1:0] m_pending;
   logic                 m_halted;
   logic [31:0]          m_protect;
   logic                 m_ime;
   logic [IRQ_LINES-1:0] m_ie;

   core_outcome_type outcome_q [$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  irq_entries = 0;
   int  mode_changes = 0;
   int  settings_used = 0;
   int  stall_left = 0;
   int  quiet_cycles = 0;
   bit  pace_on = 1'b1;

   function automatic int draw_wait();
      if (!pace_on || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic void clear_model();
      int m;
      int s;
      for (m = 0; m < NUM_LIVE; m++) m_regs[m] = '0;
      for (m = 0; m < NUM_MODES; m++) begin
         m_spsr[m] = '0;
         for (s = 0; s < BANK_SLOTS; s++) m_bank[m][s] = '0;
      end
      m_status  = '0;
      m_mode    = MODE_USER;
      m_pending = '0;
      m_halted  = 1'b0;
      m_protect = '0;
      m_ime     = 1'b0;
      m_ie      = '0;
   endfunction

   // Mode change: FIQ entry saves r8-r14 and FIQ exit restores them; otherwise only SP and LR are banked.
   function automatic void shadow_switch(logic [2:0] next);
      logic [2:0] prev;
      int         s;
      prev = m_mode;
      if (next >= NUM_MODES || next == prev) return;
      if (next == MODE_FAST) begin
         for (s = 0; s < BANK_SLOTS; s++) m_bank[prev][s] = m_regs[BANK_BASE + s];
      end else begin
         m_bank[prev][SP_SLOT] = m_regs[BANK_BASE + SP_SLOT];
         m_bank[prev][LR_SLOT] = m_regs[BANK_BASE + LR_SLOT];
      end
      if (prev == MODE_FAST) begin
         for (s = 0; s < BANK_SLOTS; s++) m_regs[BANK_BASE + s] = m_bank[next][s];
      end else begin
         m_regs[BANK_BASE + SP_SLOT] = m_bank[next][SP_SLOT];
         m_regs[BANK_BASE + LR_SLOT] = m_bank[next][LR_SLOT];
      end
      m_mode = next;
      mode_changes++;
   endfunction

   // Applies one request to the shadow state and returns the result it causes.
   function automatic core_outcome_type compute_core_outcome(logic [2:0] op, logic [4:0] idx,
         logic [31:0] data, logic [2:0] tmode, logic [IRQ_LINES-1:0] lines);
      core_outcome_type o;
      o.read_data = '0;
      o.irq_taken = 1'b0;
      case (op)
         OP_READ: begin
            if (idx < STATUS_INDEX) o.read_data = m_regs[idx[3:0]];
            else if (idx == STATUS_INDEX) o.read_data = m_status;
         end
         OP_WRITE: begin
            if (idx < STATUS_INDEX) m_regs[idx[3:0]] = data;
            else if (idx == STATUS_INDEX) m_status = data;
         end
         OP_SWITCH: shadow_switch(tmode);
         OP_RAISE: begin
            m_pending = m_pending | lines;
            if (m_ime && (m_ie & m_pending) != '0 && !m_status[STATUS_I_BIT]) begin
               m_protect = BIOS_PROTECT;
               m_bank[MODE_INTR][LR_SLOT] = m_regs[PC_INDEX] + PC_STEP;
               m_spsr[MODE_INTR] = m_status;
               m_status = IRQ_STATUS;
               m_regs[PC_INDEX] = IRQ_VECTOR;
               shadow_switch(MODE_INTR);
               m_halted = 1'b0;
               o.irq_taken = 1'b1;
               irq_entries++;
            end
         end
         OP_CLEAR: m_pending = m_pending & ~lines;
         OP_HALT:  m_halted = 1'b1;
         default: ;
      endcase
      o.current_mode = m_mode;
      o.pending_irqs = m_pending;
      o.core_running = !m_halted;
      o.pc_changed   = o.irq_taken;
      o.bios_latch   = m_protect;
      return o;
   endfunction

   // Sends one request transaction after a random gap and records its expected result.
   task automatic send_item(logic [2:0] op, logic [4:0] idx, logic [31:0] data,
         logic [2:0] tmode, logic [IRQ_LINES-1:0] lines);
      int gap;
      gap = draw_wait();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_operation   = op;
      req_reg_index   = idx;
      req_write_data  = data;
      req_target_mode = tmode;
      req_irq_lines   = lines;
      do @(posedge clock); while (req_stall);
      outcome_q.push_back(compute_core_outcome(op, idx, data, tmode, lines));
      items_sent++;
   endtask

   // Drops valid and holds until every expected result has been received.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   // Configuration write through the APB port, done only while the core is idle.
   task automatic write_csr(logic index, logic [31:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (index == CSR_MASTER_ENABLE) m_ime = value[0];
      else m_ie = value[IRQ_LINES-1:0];
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_irq_config(logic ime, logic [IRQ_LINES-1:0] ie);
      write_csr(CSR_MASTER_ENABLE, {31'd0, ime});
      write_csr(CSR_LINE_ENABLE, {{(32-IRQ_LINES){1'b0}}, ie});
      settings_used++;
   endtask

   // Register reads and writes, index extremes and the unused operation codes.
   task automatic test_register_access();
      send_item(OP_WRITE, 5'd0, 32'hFFFF_FFFF, 3'd7, '0);
      send_item(OP_READ, 5'd0, 32'h0, 3'd0, ALL_LINES);
      send_item(OP_WRITE, {1'b0, PC_INDEX}, 32'h0, 3'd0, '0);
      send_item(OP_WRITE, STATUS_INDEX, 32'hFFFF_FFFF, 3'd0, '0);
      send_item(OP_READ, STATUS_INDEX, 32'hFFFF_FFFF, 3'd0, '0);
      send_item(OP_WRITE, STATUS_INDEX, 32'h0, 3'd0, '0);
      send_item(OP_WRITE, 5'd31, 32'hFFFF_FFFF, 3'd0, '0);
      send_item(OP_READ, 5'd31, 32'h0, 3'd0, '0);
      send_item(OP_READ, 5'd17, 32'h0, 3'd0, '0);
      send_item(OP_SPARE_LO, 5'd0, 32'hFFFF_FFFF, MODE_FAST, ALL_LINES);
      send_item(OP_SPARE_HI, STATUS_INDEX, 32'hFFFF_FFFF, MODE_INTR, ALL_LINES);
   endtask

   // FIQ entry and exit, a repeated switch and modes beyond the last one.
   task automatic test_mode_switching();
      send_item(OP_WRITE, SP_INDEX, 32'h1357_9BDF, 3'd0, '0);
      send_item(OP_WRITE, 5'd8, 32'h8888_0008, 3'd0, '0);
      send_item(OP_SWITCH, 5'd0, 32'h0, MODE_FAST, '0);
      send_item(OP_READ, 5'd8, 32'h0, 3'd0, '0);
      send_item(OP_SWITCH, 5'd0, 32'h0, MODE_FAST, '0);
      send_item(OP_SWITCH, 5'd0, 32'h0, 3'd7, '0);
      send_item(OP_SWITCH, 5'd0, 32'h0, MODE_USER, '0);
      send_item(OP_READ, SP_INDEX, 32'h0, 3'd0, '0);
      send_item(OP_SWITCH, 5'd0, 32'h0, MODE_UND, '0);
   endtask

   // Interrupt entry from a halted core, blocking by the I bit, entry while in IRQ
   // mode, and blocking by the line mask and by the master enable.
   task automatic test_irq_entry();
      set_irq_config(1'b1, ALL_LINES);
      send_item(OP_HALT, 5'd0, 32'h0, 3'd0, '0);
      send_item(OP_RAISE, 5'd0, 32'h0, 3'd0, 14'h2001);
      send_item(OP_RAISE, 5'd0, 32'h0, 3'd0, 14'h0001);
      send_item(OP_WRITE, STATUS_INDEX, 32'h0000_001F, 3'd0, '0);
      send_item(OP_RAISE, 5'd0, 32'h0, 3'd0, 14'h0002);
      send_item(OP_READ, LR_INDEX, 32'h0, 3'd0, '0);
      send_item(OP_CLEAR, 5'd0, 32'h0, 3'd0, ALL_LINES);
      send_item(OP_WRITE, STATUS_INDEX, 32'h0, 3'd0, '0);
      set_irq_config(1'b1, '0);
      send_item(OP_RAISE, 5'd0, 32'h0, 3'd0, ALL_LINES);
      set_irq_config(1'b0, ALL_LINES);
      send_item(OP_RAISE, 5'd0, 32'h0, 3'd0, ALL_LINES);
   endtask

   function automatic logic [IRQ_LINES-1:0] pick_lines();
      if ($urandom_range(0, 1) == 0)
         return IRQ_LINES'(1) << $urandom_range(0, IRQ_LINES - 1);
      return IRQ_LINES'($urandom);
   endfunction

   function automatic logic [31:0] pick_status();
      logic [31:0] v;
      v = $urandom;
      if ($urandom_range(0, 9) < 7) v[STATUS_I_BIT] = 1'b0;
      return v;
   endfunction

   // One random transaction of any kind, unused codes and bad indexes included.
   task automatic random_transaction();
      int          pick;
      logic [4:0]  idx;
      logic [31:0] data;
      pick = $urandom_range(0, 99);
      idx  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                         : 5'($urandom_range(0, 16));
      data = (idx == STATUS_INDEX) ? pick_status() : $urandom;
      if (pick < 20)
         send_item(OP_READ, idx, $urandom, 3'($urandom), IRQ_LINES'($urandom));
      else if (pick < 45)
         send_item(OP_WRITE, idx, data, 3'($urandom), IRQ_LINES'($urandom));
      else if (pick < 62)
         send_item(OP_SWITCH, 5'($urandom), $urandom, 3'($urandom), IRQ_LINES'($urandom));
      else if (pick < 80)
         send_item(OP_RAISE, 5'($urandom), $urandom, 3'($urandom), pick_lines());
      else if (pick < 90)
         send_item(OP_CLEAR, 5'($urandom), $urandom, 3'($urandom), IRQ_LINES'($urandom));
      else if (pick < 95)
         send_item(OP_HALT, 5'($urandom), $urandom, 3'($urandom), IRQ_LINES'($urandom));
      else
         send_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 5'($urandom), $urandom,
                   3'($urandom), IRQ_LINES'($urandom));
   endtask

   // A handler-like round: unmask, raise, inspect LR and PC, acknowledge, return.
   task automatic irq_round();
      logic [IRQ_LINES-1:0] lines;
      lines = pick_lines();
      send_item(OP_WRITE, STATUS_INDEX, pick_status(), 3'($urandom), IRQ_LINES'($urandom));
      if ($urandom_range(0, 3) == 0)
         send_item(OP_HALT, 5'($urandom), $urandom, 3'($urandom), '0);
      send_item(OP_RAISE, 5'($urandom), $urandom, 3'($urandom), lines);
      send_item(OP_READ, LR_INDEX, $urandom, 3'($urandom), IRQ_LINES'($urandom));
      send_item(OP_READ, {1'b0, PC_INDEX}, $urandom, 3'($urandom), IRQ_LINES'($urandom));
      send_item(OP_WRITE, 5'($urandom_range(8, 15)), $urandom, 3'($urandom),
                IRQ_LINES'($urandom));
      send_item(OP_CLEAR, 5'($urandom), $urandom, 3'($urandom), lines);
      send_item(OP_SWITCH, 5'($urandom), $urandom, 3'($urandom_range(0, 7)),
                IRQ_LINES'($urandom));
   endtask

   // Random phases, each under its own interrupt configuration and pacing.
   task automatic test_random_traffic();
      int phase;
      int goal;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_irq_config(1'b1, ALL_LINES);
            1: set_irq_config(1'b1, IRQ_LINES'($urandom));
            2: set_irq_config(1'b0, ALL_LINES);
            3: set_irq_config(1'b1, '0);
            4: set_irq_config(1'b1, IRQ_LINES'(1) << $urandom_range(0, IRQ_LINES - 1));
            default: set_irq_config(1'b1, ALL_LINES);
         endcase
         pace_on = (phase != 2 && phase != 4);
         goal = items_sent + RANDOM_ITEMS / 6;
         while (items_sent < goal) begin
            if ($urandom_range(0, 9) < 6) irq_round();
            else random_transaction();
            // Let the pipeline empty in the middle of every phase.
            if (items_sent >= goal - RANDOM_ITEMS / 12 && items_sent < goal - RANDOM_ITEMS / 12 + 8)
               wait_drained();
         end
      end
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
         mismatches++;
      end
   endfunction

   // Result checker; also draws the stall that follows each accepted result.
   always @(posedge clock) begin : check_results
      core_outcome_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            $error("result transaction arrived with no request outstanding");
            mismatches++;
         end else begin
            due = outcome_q.pop_front();
            compare_field("read_data", due.read_data, rsp_read_data);
            compare_field("irq_taken", 32'(due.irq_taken), 32'(rsp_irq_taken));
            compare_field("current_mode", 32'(due.current_mode), 32'(rsp_current_mode));
            compare_field("pending_irqs", 32'(due.pending_irqs), 32'(rsp_pending_irqs));
            compare_field("core_running", 32'(due.core_running), 32'(rsp_core_running));
            compare_field("pc_changed", 32'(due.pc_changed), 32'(rsp_pc_changed));
            compare_field("bios_latch", due.bios_latch, rsp_bios_latch);
         end
         results_seen++;
         stall_left = draw_wait();
      end
   end

   // Result-side back-pressure.
   always @(negedge clock) begin
      rsp_stall = (stall_left > 0);
      if (stall_left > 0) stall_left--;
   end

   // Watchdog on cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_READ;
      req_reg_index   = '0;
      req_write_data  = '0;
      req_target_mode = MODE_USER;
      req_irq_lines   = '0;
      rsp_stall       = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      clear_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_access();
      test_mode_switching();
      test_irq_entry();
      test_random_traffic();

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Covered %0d transactions and %0d results, with %0d interrupt entries",
               items_sent, results_seen, irq_entries);
      $display("and %0d mode changes across %0d interrupt enable settings.",
               mode_changes, settings_used);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/brm_pkg.sv
rtl/brm_csr.sv
rtl/brm_regs.sv
rtl/banked_register_mode_and_irq_entry_core.sv
tb/tb_banked_register_mode_and_irq_entry_core.sv
